>>> sv/gpio_pkg.sv
`timescale 1ns / 1ps

package gpio_pkg;

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_SAMPLE = 2'd2
    } action_t;

    typedef enum logic [3:0] {
        REG_MODE    = 4'd0,
        REG_OTYPE   = 4'd1,
        REG_SPEED   = 4'd2,
        REG_PULL    = 4'd3,
        REG_IDR     = 4'd4,
        REG_ODR     = 4'd5,
        REG_SET     = 4'd6,
        REG_RESET   = 4'd7,
        REG_ALTFN0  = 4'd8,
        REG_ALTFN1  = 4'd9,
        REG_RISE    = 4'd10,
        REG_FALL    = 4'd11,
        REG_MASK    = 4'd12,
        REG_PENDING = 4'd13
    } reg_idx_t;

    localparam int unsigned NUM_PINS = 16;

    localparam logic [1:0] FIELD_OUTPUT    = 2'd1;
    localparam logic [1:0] FIELD_PULL_UP   = 2'd1;
    localparam logic [1:0] FIELD_PULL_DOWN = 2'd2;

    // interrupt groups: pins 0-1, 2-3, 4-15
    localparam logic [15:0] IRQ_GRP0_MASK = 16'h0003;
    localparam logic [15:0] IRQ_GRP1_MASK = 16'h000C;
    localparam logic [15:0] IRQ_GRP2_MASK = 16'hFFF0;

    typedef logic [NUM_PINS-1:0] pins_t;

    typedef struct packed {
        logic [31:0] mode_bits;
        pins_t       open_drain_bits;
        logic [31:0] speed_bits;
        logic [31:0] pull_bits;
        pins_t       output_levels;
        pins_t       input_levels;
        logic [31:0] altfn0;
        logic [31:0] altfn1;
        pins_t       rise_select;
        pins_t       fall_select;
        pins_t       line_mask;
        pins_t       pending_flags;
    } gpio_state_t;

    typedef struct packed {
        logic        take;
        logic [1:0]  action;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        pins_t       pad_levels;
    } gpio_beat_t;

    // one bit per pin, set where the pin's two-bit field equals code
    function automatic pins_t field_match(input logic [31:0] word, input logic [1:0] code);
        pins_t r;
        r = '0;
        for (int p = 0; p < NUM_PINS; p++) begin
            r[p] = (word[2*p +: 2] == code);
        end
        return r;
    endfunction

endpackage

>>> sv/gpio_req_if.sv
`timescale 1ns / 1ps

interface gpio_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
    logic [15:0] pad_levels;

    modport source (
        output valid, action, reg_index, write_data, pad_levels,
        input  ready
    );

    modport sink (
        input  valid, action, reg_index, write_data, pad_levels,
        output ready
    );
endinterface

>>> sv/gpio_rsp_if.sv
`timescale 1ns / 1ps

interface gpio_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [15:0] pad_drive;
    logic [15:0] pad_enable;
    logic [15:0] pull_up_enable;
    logic [15:0] pull_down_enable;
    logic [2:0]  irq_lines;

    modport source (
        output valid, read_data, pad_drive, pad_enable, pull_up_enable,
               pull_down_enable, irq_lines,
        input  ready
    );

    modport sink (
        input  valid, read_data, pad_drive, pad_enable, pull_up_enable,
               pull_down_enable, irq_lines,
        output ready
    );
endinterface

>>> sv/gpio_regs.sv
`timescale 1ns / 1ps

module gpio_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gpio_pkg::gpio_beat_t beat,
    output gpio_pkg::gpio_state_t state_next
);

    gpio_pkg::gpio_state_t state_reg;
    gpio_pkg::pins_t       edges;
    gpio_pkg::pins_t       wr_lo;
    gpio_pkg::pins_t       wr_hi;

    assign wr_lo = beat.write_data[15:0];
    assign wr_hi = beat.write_data[31:16];

    always_comb
    begin
        state_next = state_reg;

        // sample pads first, then edge detect against the previous sample
        edges = ((beat.pad_levels & ~state_reg.input_levels & state_reg.rise_select) |
                 (~beat.pad_levels & state_reg.input_levels & state_reg.fall_select)) &
                state_reg.line_mask;
        state_next.input_levels  = beat.pad_levels;
        state_next.pending_flags = state_reg.pending_flags | edges;

        if (beat.action == gpio_pkg::ACT_WRITE)
        begin
            case (beat.reg_index)
                gpio_pkg::REG_MODE:    state_next.mode_bits       = beat.write_data;
                gpio_pkg::REG_OTYPE:   state_next.open_drain_bits = wr_lo;
                gpio_pkg::REG_SPEED:   state_next.speed_bits      = beat.write_data;
                gpio_pkg::REG_PULL:    state_next.pull_bits       = beat.write_data;
                gpio_pkg::REG_ODR:     state_next.output_levels   = wr_lo;
                // set half wins over clear half
                gpio_pkg::REG_SET:     state_next.output_levels =
                                           (state_reg.output_levels & ~wr_hi) | wr_lo;
                gpio_pkg::REG_RESET:   state_next.output_levels =
                                           state_reg.output_levels & ~wr_lo;
                gpio_pkg::REG_ALTFN0:  state_next.altfn0          = beat.write_data;
                gpio_pkg::REG_ALTFN1:  state_next.altfn1          = beat.write_data;
                gpio_pkg::REG_RISE:    state_next.rise_select     = wr_lo;
                gpio_pkg::REG_FALL:    state_next.fall_select     = wr_lo;
                gpio_pkg::REG_MASK:    state_next.line_mask       = wr_lo;
                // a fresh edge beats the clear
                gpio_pkg::REG_PENDING: state_next.pending_flags =
                                           (state_reg.pending_flags & ~wr_lo) | edges;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (beat.take)
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/gpio_port_with_edge_interrupts.sv
`timescale 1ns / 1ps

// channel  dir  handshake      payload
// req      in   valid/ready    action, reg_index, write_data, pad_levels
// rsp      out  valid/ready    read_data, pad_drive, pad_enable, pull_up_enable,
//                              pull_down_enable, irq_lines
//
// one beat per clock; the result is registered, shown the cycle after the request beat
// the single result register sets the rate: req.ready is high while it is
// empty or being drained, so a stalled rsp stalls req
// async reset clears all bank registers and the result valid

module gpio_port_with_edge_interrupts (
    input  logic              clk,
    input  logic              rst_n,
    gpio_req_if.sink          req,
    gpio_rsp_if.source        rsp
);

    gpio_pkg::gpio_beat_t  beat;
    gpio_pkg::gpio_state_t state_next;
    gpio_pkg::pins_t       live;

    logic        rsp_valid_reg;
    logic [31:0] read_data_next;
    logic [31:0] read_data_reg;
    logic [15:0] pad_drive_reg;
    logic [15:0] pad_enable_next;
    logic [15:0] pad_enable_reg;
    logic [15:0] pull_up_reg;
    logic [15:0] pull_down_reg;
    logic [2:0]  irq_next;
    logic [2:0]  irq_reg;

    assign req.ready = !rsp_valid_reg || rsp.ready;

    assign beat.take       = req.valid && req.ready;
    assign beat.action     = req.action;
    assign beat.reg_index  = req.reg_index;
    assign beat.write_data = req.write_data;
    assign beat.pad_levels = req.pad_levels;

    gpio_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .state_next (state_next)
    );

    always_comb
    begin
        read_data_next = '0;
        if (req.action == gpio_pkg::ACT_READ)
        begin
            case (req.reg_index)
                gpio_pkg::REG_MODE:    read_data_next = state_next.mode_bits;
                gpio_pkg::REG_OTYPE:   read_data_next = {16'd0, state_next.open_drain_bits};
                gpio_pkg::REG_SPEED:   read_data_next = state_next.speed_bits;
                gpio_pkg::REG_PULL:    read_data_next = state_next.pull_bits;
                gpio_pkg::REG_IDR:     read_data_next = {16'd0, state_next.input_levels};
                gpio_pkg::REG_ODR:     read_data_next = {16'd0, state_next.output_levels};
                gpio_pkg::REG_ALTFN0:  read_data_next = state_next.altfn0;
                gpio_pkg::REG_ALTFN1:  read_data_next = state_next.altfn1;
                gpio_pkg::REG_RISE:    read_data_next = {16'd0, state_next.rise_select};
                gpio_pkg::REG_FALL:    read_data_next = {16'd0, state_next.fall_select};
                gpio_pkg::REG_MASK:    read_data_next = {16'd0, state_next.line_mask};
                gpio_pkg::REG_PENDING: read_data_next = {16'd0, state_next.pending_flags};
                default:               read_data_next = '0;
            endcase
        end
    end

    // open drain pins only drive while low
    assign pad_enable_next = gpio_pkg::field_match(state_next.mode_bits, gpio_pkg::FIELD_OUTPUT) &
                             (~state_next.open_drain_bits | ~state_next.output_levels);

    assign live     = state_next.pending_flags & state_next.line_mask;
    assign irq_next = {|(live & gpio_pkg::IRQ_GRP2_MASK),
                       |(live & gpio_pkg::IRQ_GRP1_MASK),
                       |(live & gpio_pkg::IRQ_GRP0_MASK)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            rsp_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat.take)
        begin
            read_data_reg  <= read_data_next;
            pad_drive_reg  <= state_next.output_levels;
            pad_enable_reg <= pad_enable_next;
            pull_up_reg    <= gpio_pkg::field_match(state_next.pull_bits,
                                                    gpio_pkg::FIELD_PULL_UP);
            pull_down_reg  <= gpio_pkg::field_match(state_next.pull_bits,
                                                    gpio_pkg::FIELD_PULL_DOWN);
            irq_reg        <= irq_next;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.read_data        = read_data_reg;
    assign rsp.pad_drive        = pad_drive_reg;
    assign rsp.pad_enable       = pad_enable_reg;
    assign rsp.pull_up_enable   = pull_up_reg;
    assign rsp.pull_down_enable = pull_down_reg;
    assign rsp.irq_lines        = irq_reg;

`ifndef SYNTHESIS
    a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> rsp.valid)
        else $error("request beat produced no result");

    a_no_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.action != gpio_pkg::ACT_READ)
        |=> (rsp.read_data == 32'd0))
        else $error("non-read beat returned data");

    a_idr_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.action == gpio_pkg::ACT_READ &&
         req.reg_index == gpio_pkg::REG_IDR)
        |=> (rsp.read_data == {16'd0, $past(req.pad_levels)}))
        else $error("idr read does not show this beat's pads");

    a_odr_write: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.action == gpio_pkg::ACT_WRITE &&
         req.reg_index == gpio_pkg::REG_ODR)
        |=> (rsp.pad_drive == $past(req.write_data[15:0])))
        else $error("odr write not reflected on pad_drive");
`endif

endmodule
